/* sv/bspline_lattice_fit_accumulator_unit_macros.svh */
`ifndef BSPLINE_LATTICE_FIT_ACCUMULATOR_UNIT_MACROS_SVH
`define BSPLINE_LATTICE_FIT_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define LFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define LFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/lfa_pkg.sv */
`default_nettype none
package lfa_pkg;
  localparam int MAX_CELLS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_OUTSIDE = 2'd1;
  localparam logic [1:0] STS_RANGE   = 2'd2;

  localparam int NUM_W   = 48;
  localparam int WS_W    = 32;
  localparam int ENTRY_W = NUM_W + WS_W;
  localparam int DVD_W   = 65;
  localparam int B_W     = 17;
endpackage
`default_nettype wire

/* sv/lfa_store.sv */
`default_nettype none
module lfa_store #(
  parameter int DEPTH = 4624,
  parameter int AW    = 13
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [lfa_pkg::ENTRY_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [lfa_pkg::ENTRY_W-1:0] rdata
);
  logic [lfa_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/lfa_div.sv */
`default_nettype none
module lfa_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lfa_pkg::DVD_W-1:0] dividend,
  input  wire logic [31:0]               divisor,
  output logic                           done,
  output logic      [lfa_pkg::DVD_W-1:0] quotient
);
  logic [lfa_pkg::DVD_W-1:0] quo_r;
  logic [31:0]               rem_r;
  logic [31:0]               div_r;
  logic [6:0]                cnt_r;
  logic                      run_r;
  logic [32:0]               shifted;
  logic [32:0]               diff;

  assign shifted  = {rem_r, quo_r[lfa_pkg::DVD_W-1]};
  assign diff     = shifted - {1'b0, div_r};
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        quo_r <= dividend;
        rem_r <= '0;
        div_r <= divisor;
        cnt_r <= 7'(lfa_pkg::DVD_W - 1);
      end else if (run_r) begin
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[lfa_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[31:0];
          quo_r <= {quo_r[lfa_pkg::DVD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == '0) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/lfa_wgt.sv */
`default_nettype none
module lfa_wgt (
  input  wire logic                              clk,
  input  wire logic [15:0]                       t_i,
  output logic      [3:0][lfa_pkg::B_W-1:0]      b_o
);
  localparam logic [40:0] RECIP6 = 41'd1398102;

  logic [15:0] t1_r;
  logic [31:0] t2_r;
  logic [16:0] s1_r;
  logic [33:0] s2_r;
  logic [15:0] t1b_r;
  logic [31:0] t2b_r;
  logic [47:0] t3_r;
  logic [50:0] s3_r;
  logic [3:0][20:0] n_r;
  logic [16:0] s;
  logic signed [55:0] six [4];

  assign s = 17'h10000 - {1'b0, t_i};

  always_comb begin
    six[0] = $signed({5'b0, s3_r});
    six[1] = 56'sd3 * $signed({8'b0, t3_r}) - ($signed({24'b0, t2b_r}) * 56'sd6 <<< 16)
             + (56'sd4 <<< 48);
    six[2] = -(56'sd3 * $signed({8'b0, t3_r})) + ($signed({24'b0, t2b_r}) * 56'sd3 <<< 16)
             + ($signed({40'b0, t1b_r}) * 56'sd3 <<< 32) + (56'sd1 <<< 48);
    six[3] = $signed({8'b0, t3_r});
  end

  always_ff @(posedge clk) begin
    t1_r  <= t_i;
    t2_r  <= 32'(t_i) * 32'(t_i);
    s1_r  <= s;
    s2_r  <= 34'(s) * 34'(s);
    t1b_r <= t1_r;
    t2b_r <= t2_r;
    t3_r  <= 48'(t2_r) * 48'(t1_r);
    s3_r  <= 51'(s2_r) * 51'(s1_r);
    for (int i = 0; i < 4; i++) begin
      n_r[i] <= 21'(six[i][55:32]) + 21'd3;
      b_o[i] <= 17'((41'(n_r[i]) * RECIP6) >> 23);
    end
  end
endmodule
`default_nettype wire

/* sv/bspline_lattice_fit_accumulator_unit.sv */
`default_nettype none
// Add: runs the weight pipeline, forms the weight products, then per footprint cell divides on
// the shared 65-step divider (unless the squared-weight sum is zero) and writes the cell back.
// Read: a store read, then a divide unless the cell is empty. Clear: zeroes all (MAX_CELLS+4)^2
// entries. Rejected and unused items: never busy. One item at a time; the result strobe follows
// the last busy cycle, cannot be stalled, and the next item may start. Reset (synchronous, rst_n
// low) sets lattice_cells to 1, then zeroes all (MAX_CELLS+4)^2 store entries with busy high.
module bspline_lattice_fit_accumulator_unit #(
  parameter int MAX_CELLS = lfa_pkg::MAX_CELLS_DEF,
  parameter int FRAC_BITS = lfa_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic signed [22:0] in_pos_x,
  input  wire logic signed [22:0] in_pos_y,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic [6:0]         in_cell_x,
  input  wire logic [6:0]         in_cell_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [6:0]         cfg_lattice_cells,
  output logic                    out_valid,
  output logic signed [31:0]      out_coefficient,
  output logic [1:0]              out_status
);
  localparam int SIDE  = MAX_CELLS + 4;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_CELLS + 5);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WGT, S_WA, S_WB, S_PA, S_PB, S_DIV, S_MA, S_MB, S_RMW,
    S_RRD, S_RDAT, S_RDIV
  } state_t;

  state_t state_r;
  logic [6:0]    cells_r;
  logic [AW-1:0] clr_r;
  logic          clr_rsp_r;
  logic [1:0]    op_r;
  logic [CW-1:0] ix_r, iy_r, cx_r, cy_r;
  logic          zneg_r;
  logic [32:0]   zmag_r;
  logic [15:0]   tx_r, ty_r;
  logic [2:0]    wcnt_r;
  logic [3:0]    k_r;
  logic [32:0]   w_r;
  logic [25:0]   w2a_r [16];
  logic [31:0]   sw2_r;
  logic [63:0]   r_r;
  logic [57:0]   pl_r;
  logic [65:0]   tmag_r;
  logic          rneg_r;

  logic [3:0][lfa_pkg::B_W-1:0] bx, by;
  logic [31:0] cells_eff;
  logic [21:0] ixc, iyc;
  logic        outside, rd_bad;
  logic [AW-1:0] fp_addr, rd_addr, raddr, waddr;
  logic [lfa_pkg::ENTRY_W-1:0] rdata, wdata;
  logic        we;
  logic [65:0] wsq;
  logic [25:0] w2c;
  logic [24:0] wq;
  logic [lfa_pkg::DVD_W-1:0] dvd_fp, dvd_rd, dvd, quo;
  logic [31:0] dvs;
  logic        div_start, div_done;
  logic [89:0] pfull;
  logic signed [47:0] num_old;
  logic signed [67:0] acc;
  logic [47:0] acc_sat;
  logic [32:0] ws_sum;
  logic [31:0] ws_rd;
  logic [47:0] mag_rd;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cells_r == 7'd0) begin
      cells_eff = 32'd1;
    end else if (32'(cells_r) > 32'(MAX_CELLS)) begin
      cells_eff = 32'(MAX_CELLS);
    end else begin
      cells_eff = 32'(cells_r);
    end
  end

  assign ixc     = in_pos_x[21:0] >> FRAC_BITS;
  assign iyc     = in_pos_y[21:0] >> FRAC_BITS;
  assign outside = in_pos_x[22] || in_pos_y[22] || (32'(ixc) > cells_eff) ||
                   (32'(iyc) > cells_eff);
  assign rd_bad  = (32'(in_cell_x) >= cells_eff + 32'd4) ||
                   (32'(in_cell_y) >= cells_eff + 32'd4);

  assign fp_addr = AW'((32'(iy_r) + 32'(k_r[3:2])) * 32'(SIDE) + 32'(ix_r) + 32'(k_r[1:0]));
  assign rd_addr = AW'(32'(cy_r) * 32'(SIDE) + 32'(cx_r));
  assign raddr   = (op_r == lfa_pkg::OP_READ) ? rd_addr : fp_addr;

  assign wsq = 66'(w_r) * 66'(w_r);
  assign w2c = 26'((wsq + (66'd1 << 39)) >> 40);
  assign wq  = 25'((w_r + 33'd128) >> 8);
  assign dvd_fp = ((65'(wq) * 65'(zmag_r)) << 8) + 65'(sw2_r >> 1);

  assign ws_rd  = rdata[79:48];
  assign num_old = $signed(rdata[47:0]);
  assign mag_rd = num_old[47] ? 48'(-num_old) : 48'(num_old);
  assign dvd_rd = {1'b0, mag_rd, 16'b0} + 65'(ws_rd >> 1);

  assign dvd = (state_r == S_PB) ? dvd_fp : dvd_rd;
  assign dvs = (state_r == S_PB) ? sw2_r : ws_rd;
  assign div_start = ((state_r == S_PB) && (sw2_r != '0)) ||
                     ((state_r == S_RDAT) && (ws_rd != '0));

  assign pfull = 90'(pl_r) + ((90'(w2a_r[k_r]) * 90'(r_r[63:32])) << 32);

  always_comb begin
    acc = 68'(num_old) + (zneg_r ? -$signed({2'b0, tmag_r}) : $signed({2'b0, tmag_r}));
    if (acc > 68'sh7FFFFFFFFFFF) begin
      acc_sat = 48'h7FFFFFFFFFFF;
    end else if (acc < -68'sh800000000000) begin
      acc_sat = 48'h800000000000;
    end else begin
      acc_sat = acc[47:0];
    end
    ws_sum = {1'b0, ws_rd} + 33'(w2a_r[k_r]);
  end

  always_comb begin
    if (state_r == S_CLR) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else begin
      we    = (state_r == S_RMW);
      waddr = fp_addr;
      wdata = {(ws_sum[32] ? 32'hFFFFFFFF : ws_sum[31:0]), acc_sat};
    end
  end

  lfa_wgt u_wgt_x (.clk(clk), .t_i(tx_r), .b_o(bx));
  lfa_wgt u_wgt_y (.clk(clk), .t_i(ty_r), .b_o(by));

  lfa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(quo)
  );

  lfa_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cells_r   <= 7'd1;
      clr_r     <= '0;
      clr_rsp_r <= 1'b0;
      op_r      <= lfa_pkg::OP_ADD;
      out_valid <= 1'b0;
      out_coefficient <= '0;
      out_status <= lfa_pkg::STS_DONE;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid) begin
        cells_r <= cfg_lattice_cells;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == 32'(DEPTH - 1)) begin
            state_r <= S_IDLE;
            if (clr_rsp_r) begin
              out_valid       <= 1'b1;
              out_coefficient <= '0;
              out_status      <= lfa_pkg::STS_DONE;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r   <= in_operation;
            ix_r   <= CW'(ixc);
            iy_r   <= CW'(iyc);
            cx_r   <= CW'(in_cell_x);
            cy_r   <= CW'(in_cell_y);
            zneg_r <= in_sample_value[31];
            zmag_r <= in_sample_value[31] ? 33'h100000000 - 33'({1'b0, in_sample_value})
                                          : 33'({1'b0, in_sample_value});
            tx_r   <= 16'((40'(in_pos_x[21:0]) << (40 - FRAC_BITS)) >> 24);
            ty_r   <= 16'((40'(in_pos_y[21:0]) << (40 - FRAC_BITS)) >> 24);
            wcnt_r <= '0;
            k_r    <= '0;
            sw2_r  <= '0;
            out_coefficient <= '0;
            case (in_operation)
              lfa_pkg::OP_ADD: begin
                if (outside) begin
                  out_valid  <= 1'b1;
                  out_status <= lfa_pkg::STS_OUTSIDE;
                end else begin
                  state_r <= S_WGT;
                end
              end
              lfa_pkg::OP_READ: begin
                if (rd_bad) begin
                  out_valid  <= 1'b1;
                  out_status <= lfa_pkg::STS_RANGE;
                end else begin
                  state_r <= S_RRD;
                end
              end
              lfa_pkg::OP_CLEAR: begin
                clr_r     <= '0;
                clr_rsp_r <= 1'b1;
                state_r   <= S_CLR;
              end
              default: begin
                out_valid  <= 1'b1;
                out_status <= lfa_pkg::STS_DONE;
              end
            endcase
          end
        end
        S_WGT: begin
          wcnt_r <= wcnt_r + 3'd1;
          if (wcnt_r == 3'd5) begin
            state_r <= S_WA;
          end
        end
        S_WA: begin
          w_r     <= 33'(34'(bx[k_r[1:0]]) * 34'(by[k_r[3:2]]));
          state_r <= S_WB;
        end
        S_WB: begin
          w2a_r[k_r] <= w2c;
          sw2_r      <= sw2_r + 32'(w2c);
          k_r        <= k_r + 4'd1;
          state_r    <= (k_r == 4'd15) ? S_PA : S_WA;
        end
        S_PA: begin
          w_r     <= 33'(34'(bx[k_r[1:0]]) * 34'(by[k_r[3:2]]));
          state_r <= S_PB;
        end
        S_PB: begin
          if (sw2_r != '0) begin
            state_r <= S_DIV;
          end else begin
            r_r     <= '0;
            state_r <= S_MA;
          end
        end
        S_DIV: begin
          if (div_done) begin
            r_r     <= quo[63:0];
            state_r <= S_MA;
          end
        end
        S_MA: begin
          pl_r    <= 58'(w2a_r[k_r]) * 58'(r_r[31:0]);
          state_r <= S_MB;
        end
        S_MB: begin
          tmag_r  <= 66'((pfull + (90'd1 << 23)) >> 24);
          state_r <= S_RMW;
        end
        S_RMW: begin
          k_r <= k_r + 4'd1;
          if (k_r == 4'd15) begin
            out_valid  <= 1'b1;
            out_status <= lfa_pkg::STS_DONE;
            state_r    <= S_IDLE;
          end else begin
            state_r <= S_PA;
          end
        end
        S_RRD: begin
          state_r <= S_RDAT;
        end
        S_RDAT: begin
          rneg_r <= num_old[47];
          if (ws_rd == '0) begin
            out_valid  <= 1'b1;
            out_status <= lfa_pkg::STS_DONE;
            state_r    <= S_IDLE;
          end else begin
            state_r <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            out_valid  <= 1'b1;
            out_status <= lfa_pkg::STS_DONE;
            state_r    <= S_IDLE;
            if (rneg_r) begin
              out_coefficient <= (quo > 65'h80000000) ? 32'sh80000000 : -$signed(quo[31:0]);
            end else begin
              out_coefficient <= (quo > 65'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(quo[31:0]);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`include "bspline_lattice_fit_accumulator_unit_macros.svh"
  `LFA_ASSERT_NOW(a_strobe_idle, out_valid, !busy)
  `LFA_ASSERT_NEXT(a_busy_after_clear, start && !busy && (in_operation == lfa_pkg::OP_CLEAR), busy)
  `LFA_ASSERT_NOW(a_range_zero, out_valid && (out_status == lfa_pkg::STS_RANGE), out_coefficient == 0)
  `LFA_ASSERT_NOW(a_no_write_idle, state_r == S_IDLE, !we)
endmodule
`default_nettype wire

/* sim/lfa_checker.sv */
`timescale 1ns / 1ps
module lfa_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic signed [22:0] in_pos_x,
  input  wire logic signed [22:0] in_pos_y,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic [6:0]         in_cell_x,
  input  wire logic [6:0]         in_cell_y,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [6:0]         cfg_lattice_cells,
  input  wire logic               out_valid,
  input  wire logic signed [31:0] out_coefficient,
  input  wire logic [1:0]         out_status,
  output int                      fail_count,
  output int                      pending
);
  localparam int SIDE = lfa_pkg::MAX_CELLS_DEF + 4;
  localparam int DEPTH = SIDE * SIDE;
  localparam longint NUM_HI = 64'sh7FFFFFFFFFFF;
  localparam longint NUM_LO = -64'sh800000000000;

  typedef struct packed {
    logic [31:0] coef;
    logic [1:0]  status;
  } fit_result_t;

  longint      num_mem [DEPTH];
  logic [31:0] wsum_mem [DEPTH];
  logic [6:0]  cells_reg;
  fit_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic int used_cells();
    int c;
    c = cells_reg;
    if (c < 1) c = 1;
    if (c > lfa_pkg::MAX_CELLS_DEF) c = lfa_pkg::MAX_CELLS_DEF;
    return c;
  endfunction

  function automatic void basis(input longint t, output longint b[4]);
    longint s, t2, t3, one48, six[4];
    s = 65536 - t;
    t2 = t * t;
    t3 = t2 * t;
    one48 = 64'sd1 << 48;
    six[0] = s * s * s;
    six[1] = 3 * t3 - 6 * t2 * 65536 + 4 * one48;
    six[2] = -3 * t3 + 3 * t2 * 65536 + 3 * t * (64'sd1 << 32) + one48;
    six[3] = t3;
    for (int i = 0; i < 4; i++) b[i] = (six[i] + (64'sd3 << 32)) / (64'sd6 << 32);
  endfunction

  function automatic logic [1:0] fit_sample(input logic [22:0] px, input logic [22:0] py,
                                             input logic [31:0] z);
    longint unsigned ix, iy, w[16], w2[16], sw2, zmag, wq, r, tmag, ws;
    longint bx[4], by[4], term, acc;
    bit zneg;
    int k, idx;
    if (px[22] || py[22]) return lfa_pkg::STS_OUTSIDE;
    ix = px >> 16;
    iy = py >> 16;
    if (ix > used_cells() || iy > used_cells()) return lfa_pkg::STS_OUTSIDE;
    basis(px[15:0], bx);
    basis(py[15:0], by);
    zneg = z[31];
    zmag = zneg ? (64'h100000000 - z) : z;
    sw2 = 0;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        w[j*4+i] = by[j] * bx[i];
        w2[j*4+i] = (w[j*4+i] * w[j*4+i] + (64'd1 << 39)) >> 40;
        sw2 += w2[j*4+i];
      end
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        k = j * 4 + i;
        idx = (iy + j) * SIDE + ix + i;
        wq = (w[k] + 128) >> 8;
        r = 0;
        if (sw2 != 0) r = (((wq * zmag) << 8) + sw2 / 2) / sw2;
        tmag = (w2[k] * r + (64'd1 << 23)) >> 24;
        term = zneg ? -longint'(tmag) : longint'(tmag);
        acc = num_mem[idx] + term;
        if (acc > NUM_HI) acc = NUM_HI;
        if (acc < NUM_LO) acc = NUM_LO;
        num_mem[idx] = acc;
        ws = wsum_mem[idx] + w2[k];
        if (ws > 64'hFFFFFFFF) ws = 64'hFFFFFFFF;
        wsum_mem[idx] = ws[31:0];
      end
    return lfa_pkg::STS_DONE;
  endfunction

  function automatic fit_result_t read_coef(input int cx, input int cy);
    fit_result_t res;
    longint unsigned mag, q, ws;
    longint num;
    res = '0;
    if (cx >= used_cells() + 4 || cy >= used_cells() + 4) begin
      res.status = lfa_pkg::STS_RANGE;
      return res;
    end
    ws = wsum_mem[cy * SIDE + cx];
    res.status = lfa_pkg::STS_DONE;
    if (ws == 0) return res;
    num = num_mem[cy * SIDE + cx];
    mag = (num < 0) ? -num : num;
    q = ((mag << 16) + ws / 2) / ws;
    if (num < 0) begin
      if (q > 64'h80000000) q = 64'h80000000;
      res.coef = 32'(64'h100000000 - q);
    end else begin
      if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
      res.coef = q[31:0];
    end
    return res;
  endfunction

  task automatic wipe_lattice();
    for (int i = 0; i < DEPTH; i++) begin
      num_mem[i] = 0;
      wsum_mem[i] = 0;
    end
  endtask

  always @(posedge clk) begin
    fit_result_t exp_r, got;
    if (!rst_n) begin
      wipe_lattice();
      cells_reg = 7'd1;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        got.coef = out_coefficient;
        got.status = out_status;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected beat coef=%h status=%0d", got.coef, got.status);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected coef=%h status=%0d, got coef=%h status=%0d",
                       exp_r.coef, exp_r.status, got.coef, got.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) cells_reg = cfg_lattice_cells;
      if (start && !busy) begin
        exp_r = '0;
        case (in_operation)
          lfa_pkg::OP_ADD:   exp_r.status = fit_sample(in_pos_x, in_pos_y, in_sample_value);
          lfa_pkg::OP_READ:  exp_r = read_coef(in_cell_x, in_cell_y);
          lfa_pkg::OP_CLEAR: wipe_lattice();
          default: ;
        endcase
        expected_q.push_back(exp_r);
      end
    end
  end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [1:0]         in_operation = lfa_pkg::OP_ADD;
  logic signed [22:0] in_pos_x = '0;
  logic signed [22:0] in_pos_y = '0;
  logic signed [31:0] in_sample_value = '0;
  logic [6:0]         in_cell_x = '0;
  logic [6:0]         in_cell_y = '0;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [6:0]         cfg_lattice_cells = 7'd1;
  logic               out_valid;
  logic signed [31:0] out_coefficient;
  logic [1:0]         out_status;
  int                 fail_count;
  int                 pending;
  int                 idle_pct;
  logic [6:0]         cur_cells;

  always #5 clk = ~clk;

  bspline_lattice_fit_accumulator_unit dut (.*);
  lfa_checker chk (.*);

  task automatic send_item(input logic [1:0] op, input logic [22:0] px, input logic [22:0] py,
                           input logic [31:0] z, input logic [6:0] cx, input logic [6:0] cy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1;
    in_operation <= op;
    in_pos_x <= px;
    in_pos_y <= py;
    in_sample_value <= z;
    in_cell_x <= cx;
    in_cell_y <= cy;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_cells(input logic [6:0] v);
    drain();
    cfg_valid <= 1;
    cfg_lattice_cells <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    cur_cells = v;
  endtask

  function automatic logic [22:0] rand_pos();
    int c;
    c = (cur_cells == 0) ? 1 : (cur_cells > 64 ? 64 : cur_cells);
    case ($urandom_range(9))
      0: return $urandom;
      1: return {7'($urandom_range(c + 1, 63)), 16'($urandom)};
      default: return {7'($urandom_range(c)), 16'($urandom)};
    endcase
  endfunction

  task automatic rand_item();
    int k, c;
    logic [31:0] z;
    k = $urandom_range(99);
    c = (cur_cells == 0) ? 1 : (cur_cells > 64 ? 64 : cur_cells);
    z = ($urandom_range(9) == 0) ? {$urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF} : $urandom;
    if (k < 60) send_item(lfa_pkg::OP_ADD, rand_pos(), rand_pos(), z, 0, 0);
    else if (k < 95)
      send_item(lfa_pkg::OP_READ, 0, 0, 0,
                $urandom_range(8) == 0 ? 7'($urandom) : 7'($urandom_range(c + 3)),
                $urandom_range(8) == 0 ? 7'($urandom) : 7'($urandom_range(c + 3)));
    else if (k < 98) send_item(lfa_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    else send_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #200_000_000;
    $display("FAIL bspline_lattice_fit_accumulator_unit");
    $finish;
  end

  initial begin
    cur_cells = 7'd1;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_item(lfa_pkg::OP_ADD, 23'h000000, 23'h000000, 32'h7FFFFFFF, 0, 0);
    send_item(lfa_pkg::OP_ADD, 23'h01FFFF, 23'h01FFFF, 32'h80000000, 0, 0);
    send_item(lfa_pkg::OP_ADD, 23'h018000, 23'h008000, 32'h00010000, 0, 0);
    send_item(lfa_pkg::OP_ADD, 23'h020000, 23'h000000, 32'h1, 0, 0);
    send_item(lfa_pkg::OP_ADD, 23'h400000, 23'h000000, 32'h1, 0, 0);
    send_item(lfa_pkg::OP_ADD, 23'h7FFFFF, 23'h3FFFFF, 32'h1, 0, 0);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 4, 4);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 5, 0);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 0, 127);
    send_item(2'd3, 23'h7FFFFF, 23'h7FFFFF, 32'hFFFFFFFF, 7'h7F, 7'h7F);
    for (int i = 0; i < 4; i++)
      send_item(lfa_pkg::OP_ADD, 23'h010000, 23'h010000, 32'h7FFFFFFF, 0, 0);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 2, 2);
    send_item(lfa_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 2, 2);
    set_cells(7'd0);
    send_item(lfa_pkg::OP_ADD, 23'h010000, 23'h010000, 32'h5, 0, 0);
    set_cells(7'd127);
    send_item(lfa_pkg::OP_ADD, 23'h400000 - 1, 23'h400000 - 1, 32'h5, 0, 0);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 67, 67);
    send_item(lfa_pkg::OP_READ, 0, 0, 0, 68, 0);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_cells(7'd1);
        1: set_cells(7'd64);
        2: set_cells(7'($urandom_range(2, 63)));
        3: set_cells(7'd3);
        4: set_cells(7'd0);
        default: set_cells(7'($urandom_range(65, 127)));
      endcase
      idle_pct = (ph < 2) ? 21 : (ph < 4 ? 82 : 0);
      for (int n = 0; n < 240; n++) rand_item();
    end
    drain();
    if (fail_count == 0) $display("PASS bspline_lattice_fit_accumulator_unit");
    else $display("FAIL bspline_lattice_fit_accumulator_unit");
    $finish;
  end
endmodule
